### hw/rtl/u2u_pkg.sv
// u2u_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies

package u2u_pkg;

   localparam logic [20:0] SuppBase   = 21'h010000;
   localparam logic [15:0] HiSurrBase = 16'hD800;
   localparam logic [15:0] LoSurrBase = 16'hDC00;
   localparam logic [15:0] BmpMax     = 16'hFFFF;
   localparam logic [6:0]  UpperA     = 7'h41;
   localparam logic [6:0]  UpperZ     = 7'h5A;
   localparam logic [6:0]  CaseOffset = 7'h20;

   // number of results caused by one input byte
   localparam logic [1:0] PushNone = 2'd0;
   localparam logic [1:0] PushOne  = 2'd1;
   localparam logic [1:0] PushTwo  = 2'd2;

   typedef struct packed {
      logic [15:0] unit;
      logic        error;
      logic        last_unit;
   } result_type;

   // results from the decoder toward the output queue
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

endpackage

### hw/rtl/u2u_ifs.sv
// u2u_ifs: channel interfaces of the transcoder (byte input, unit output, csr write)
// depends on nothing

interface u2u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u2u_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] unit;
   logic        error;
   logic        last_unit;
   modport source (output valid, output unit, output error, output last_unit, input ready);
   modport sink (input valid, input unit, input error, input last_unit, output ready);
endinterface

interface u2u_csr_if;
   logic valid;
   logic ready;
   logic fold_case;
   modport source (output valid, output fold_case, input ready);
   modport sink (input valid, input fold_case, output ready);
endinterface

### hw/rtl/u2u_decode.sv
// u2u_decode: utf-8 sequence assembly state and utf-16 encoding of each byte
// depends on u2u_pkg

module u2u_decode
   import u2u_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fold_case,
   input  logic       take,
   input  logic [7:0] byte_in,
   input  logic       last_byte,
   output push_type   push
);

   logic [20:0] partial_ff, partial_in;
   logic [1:0]  owed_ff, owed_in;
   logic        discard_ff, discard_in;

   logic        do_emit;
   logic        do_fail;
   logic [20:0] cp;
   logic [20:0] cp_fold;
   logic [20:0] cp_supp;
   logic [20:0] gathered;
   logic [1:0]  owed_dec;

   always_comb begin
      partial_in = partial_ff;
      owed_in    = owed_ff;
      discard_in = discard_ff;
      do_emit    = 1'b0;
      do_fail    = 1'b0;
      cp         = 21'd0;
      gathered   = {partial_ff[14:0], byte_in[5:0]};
      owed_dec   = owed_ff - 2'd1;

      if (discard_ff) begin
         if (last_byte) begin
            discard_in = 1'b0;
         end
      end else if (owed_ff == 2'd0) begin
         if (byte_in[7] == 1'b0) begin
            partial_in = 21'd0;
            cp         = {13'd0, byte_in};
            do_emit    = 1'b1;
         end else if (byte_in[7:5] == 3'b110) begin
            partial_in = {16'd0, byte_in[4:0]};
            owed_in    = 2'd1;
            do_fail    = last_byte;
         end else if (byte_in[7:4] == 4'b1110) begin
            partial_in = {17'd0, byte_in[3:0]};
            owed_in    = 2'd2;
            do_fail    = last_byte;
         end else if (byte_in[7:3] == 5'b11110) begin
            partial_in = {18'd0, byte_in[2:0]};
            owed_in    = 2'd3;
            do_fail    = last_byte;
         end else begin
            do_fail = 1'b1;
         end
      end else if (byte_in[7:6] != 2'b10) begin
         do_fail = 1'b1;
      end else begin
         owed_in = owed_dec;
         if (owed_dec == 2'd0) begin
            partial_in = 21'd0;
            cp         = gathered;
            do_emit    = 1'b1;
         end else begin
            partial_in = gathered;
            do_fail    = last_byte;
         end
      end

      // an error drops the partial sequence and, mid-string, the rest of the string
      if (do_fail) begin
         partial_in = 21'd0;
         owed_in    = 2'd0;
         discard_in = ~last_byte;
      end
   end

   // case folding and surrogate split
   always_comb begin
      cp_fold = cp;
      if (fold_case && cp >= {14'd0, UpperA} && cp <= {14'd0, UpperZ}) begin
         cp_fold = cp + {14'd0, CaseOffset};
      end
      cp_supp = cp_fold - SuppBase;

      push.count  = PushNone;
      push.first  = '{unit: 16'd0, error: 1'b1, last_unit: 1'b1};
      push.second = '{unit: LoSurrBase | {6'd0, cp_supp[9:0]}, error: 1'b0,
                      last_unit: last_byte};
      if (take) begin
         if (do_fail) begin
            push.count = PushOne;
         end else if (do_emit) begin
            if (cp_fold <= {5'd0, BmpMax}) begin
               push.count = PushOne;
               push.first = '{unit: cp_fold[15:0], error: 1'b0, last_unit: last_byte};
            end else begin
               push.count = PushTwo;
               push.first = '{unit: HiSurrBase | {6'd0, cp_supp[19:10]}, error: 1'b0,
                              last_unit: 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 21'd0;
         owed_ff    <= 2'd0;
         discard_ff <= 1'b0;
      end else if (take) begin
         partial_ff <= partial_in;
         owed_ff    <= owed_in;
         discard_ff <= discard_in;
      end
   end

endmodule

### hw/rtl/u2u_rsp_queue.sv
// u2u_rsp_queue: four-entry result queue, takes up to two results per cycle
// depends on u2u_pkg

module u2u_rsp_queue
   import u2u_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       has_room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type  mem_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   // room for a surrogate pair
   assign has_room  = (count_ff <= 3'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != PushNone) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == PushTwo) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level, byte-stream utf-8 to utf-16 code units
// depends on u2u_pkg, u2u_ifs, u2u_decode, u2u_rsp_queue
//
// usage
//   req_chan: one utf-8 byte per transfer, last_byte flags the final byte of a string
//   rsp_chan: one utf-16 code unit per transfer; error=1 (unit 0) flags a bad or
//     cut-off string, the rest of which is then dropped; last_unit closes the string
//   csr_chan: writes fold_case (lowercase ascii A-Z); always ready, write only when idle
// a byte's results go straight into the result queue, which serves as the output register
// throughput: one byte per cycle while the queue has room; a byte gives zero, one or two results
//   (two only for a four-byte sequence, so the output keeps pace at one unit a cycle)
// req_ready is low while the four-entry result queue holds three or more units
// reset clears the sequence state, fold_case and the queue; no sweep is needed
// a stalled receiver fills the queue and then back-pressures the byte input

module utf8_to_utf16_transcoder
   import u2u_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   u2u_req_if.sink   req_chan,
   u2u_rsp_if.source rsp_chan,
   u2u_csr_if.sink   csr_chan
);

   logic       fold_case_ff;
   logic       has_room;
   logic       take;
   push_type   push;
   result_type head;

   // config register, accepted in any cycle
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_case_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         fold_case_ff <= csr_chan.fold_case;
      end
   end

   // byte transfer
   assign req_chan.ready = has_room;
   assign take           = req_chan.valid && has_room;

   u2u_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fold_case (fold_case_ff),
      .take      (take),
      .byte_in   (req_chan.byte_in),
      .last_byte (req_chan.last_byte),
      .push      (push)
   );

   // result queue doubles as the output register
   u2u_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (head)
   );

   assign rsp_chan.unit      = head.unit;
   assign rsp_chan.error     = head.error;
   assign rsp_chan.last_unit = head.last_unit;

endmodule

### sim/u2u_checker.sv
// u2u_checker: predicts the utf-16 units of the transcoder and compares each unit transfer
// depends on u2u_pkg and the channel interfaces in u2u_ifs

module u2u_checker
   import u2u_pkg::*;
(
   input  logic clock,
   input  logic reset,
   u2u_req_if   req_mon,
   u2u_rsp_if   rsp_mon,
   u2u_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   logic        fold_lower;
   logic [20:0] code_acc;
   logic [1:0]  owed;
   logic        dropping;
   result_type  units_due[$];
   int          errors = 0;

   function automatic void flag_bad(input logic fin);
      code_acc = '0;
      owed = '0;
      dropping = !fin;
      units_due.push_back('{unit: 16'h0000, error: 1'b1, last_unit: 1'b1});
   endfunction

   function automatic void encode_point(input logic [20:0] cp, input logic fin);
      logic [20:0] ofs;
      if (fold_lower && cp >= UpperA && cp <= UpperZ) begin
         cp = cp + CaseOffset;
      end
      if (cp <= BmpMax) begin
         units_due.push_back('{unit: cp[15:0], error: 1'b0, last_unit: fin});
      end else begin
         ofs = cp - SuppBase;
         units_due.push_back('{unit: HiSurrBase | {6'd0, ofs[19:10]}, error: 1'b0,
                               last_unit: 1'b0});
         units_due.push_back('{unit: LoSurrBase | {6'd0, ofs[9:0]}, error: 1'b0,
                               last_unit: fin});
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      logic [20:0] cp;
      if (dropping) begin
         if (fin) dropping = 1'b0;
      end else if (owed == 2'd0) begin
         if (!b[7]) begin
            code_acc = '0;
            encode_point({13'd0, b}, fin);
         end else if (b[7:5] == 3'b110) begin
            code_acc = {16'd0, b[4:0]};
            owed = 2'd1;
            if (fin) flag_bad(fin);
         end else if (b[7:4] == 4'b1110) begin
            code_acc = {17'd0, b[3:0]};
            owed = 2'd2;
            if (fin) flag_bad(fin);
         end else if (b[7:3] == 5'b11110) begin
            code_acc = {18'd0, b[2:0]};
            owed = 2'd3;
            if (fin) flag_bad(fin);
         end else begin
            flag_bad(fin);
         end
      end else if (b[7:6] != 2'b10) begin
         flag_bad(fin);
      end else begin
         code_acc = {code_acc[14:0], b[5:0]};
         owed = owed - 2'd1;
         if (owed == 2'd0) begin
            cp = code_acc;
            code_acc = '0;
            encode_point(cp, fin);
         end else if (fin) begin
            flag_bad(fin);
         end
      end
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         fold_lower = 1'b0;
         code_acc = '0;
         owed = '0;
         dropping = 1'b0;
         units_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{unit: rsp_mon.unit, error: rsp_mon.error, last_unit: rsp_mon.last_unit};
            if (units_due.size() == 0) begin
               $error("unit transfer with nothing expected: unit %h error %b last_unit %b",
                      got.unit, got.error, got.last_unit);
               errors++;
            end else begin
               want = units_due.pop_front();
               if (got.unit !== want.unit) begin
                  $error("unit: expected %h, got %h", want.unit, got.unit);
                  errors++;
               end
               if (got.error !== want.error) begin
                  $error("error: expected %b, got %b", want.error, got.error);
                  errors++;
               end
               if (got.last_unit !== want.last_unit) begin
                  $error("last_unit: expected %b, got %b", want.last_unit, got.last_unit);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.byte_in, req_mon.last_byte);
         end
         if (csr_mon.valid && csr_mon.ready) begin
            fold_lower = csr_mon.fold_case;
         end
      end
      fail_count <= errors;
      pending <= units_due.size();
   end

endmodule

### sim/utf8_to_utf16_transcoder_test.sv
// utf8_to_utf16_transcoder_test: drives utf-8 strings into the transcoder with random idling
// depends on u2u_pkg, u2u_ifs, the transcoder rtl and u2u_checker

module utf8_to_utf16_transcoder_test;
   import u2u_pkg::*;

   // generous cap: ~450 bytes, each with a long gap and two long receiver stalls
   localparam int CycleLimit = 400000;
   localparam logic Last = 1'b1;
   localparam logic More = 1'b0;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;

   // bytes of the string being built for the random part
   logic [7:0] text[$];

   u2u_req_if req_chan ();
   u2u_rsp_if rsp_chan ();
   u2u_csr_if csr_chan ();

   utf8_to_utf16_transcoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // watches all three channels, owns prediction and comparison
   u2u_checker unit_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // utf-8 encoding of cp in len bytes, first byte in the top lane
   function automatic logic [31:0] utf8_pack(input logic [20:0] cp, input int len);
      case (len)
         1: begin
            return {1'b0, cp[6:0], 24'h0};
         end
         2: begin
            return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
         end
         3: begin
            return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
         end
         default: begin
            return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
         end
      endcase
   endfunction

   // append the first count bytes of a random len-byte character to text
   function automatic void append_char(input int len, input int count);
      logic [20:0] cp;
      logic [31:0] seq;
      case (len)
         1: begin
            // lean on the letters and their neighbors for the case folding
            cp = ($urandom_range(0, 2) == 0) ? 21'($urandom_range(8'h40, 8'h5B))
                                              : 21'($urandom_range(0, 8'h7F));
         end
         2: begin
            cp = 21'($urandom_range(0, 16'h07FF));
         end
         3: begin
            cp = 21'($urandom_range(0, 16'hFFFF));
         end
         default: begin
            // mostly real supplementary planes, the rest anything up to 21 bits
            cp = ($urandom_range(0, 9) < 7) ? 21'($urandom_range(32'h10000, 32'h10FFFF))
                                            : 21'($urandom_range(0, 32'h1FFFFF));
         end
      endcase
      seq = utf8_pack(cp, len);
      for (int k = 0; k < count; k++) begin
         text.push_back(seq[31 - 8 * k -: 8]);
      end
   endfunction

   function automatic int char_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 1;
      if (r < 65) return 2;
      if (r < 82) return 3;
      return 4;
   endfunction

   // builds one string into text; returns how many of its bytes the block acts on
   function automatic int make_string();
      int n;
      int flaw;
      int flaw_at;
      int mode;
      int len;
      int live;
      text.delete();
      n = $urandom_range(1, 12);
      flaw = $urandom_range(0, 99);
      live = -1;
      if (flaw >= 95) begin
         // plain noise
         repeat (n) text.push_back(8'($urandom_range(0, 255)));
         return n;
      end
      flaw_at = (flaw < 18) ? $urandom_range(0, n - 1) : n;
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         if (i != flaw_at) begin
            len = char_len();
            append_char(len, len);
         end else if (mode == 0) begin
            // bad lead byte at a character boundary
            text.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                       : 8'($urandom_range(8'hF8, 8'hFF)));
            live = text.size();
         end else begin
            // lead plus too few continuations, then a non-continuation or the end
            len = $urandom_range(2, 4);
            append_char(len, $urandom_range(1, len - 1));
            if (mode == 1) begin
               text.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h7F))
                                                          : 8'($urandom_range(8'hC0, 8'hFF)));
            end
            live = text.size();
            if (mode == 2) break;
         end
      end
      return (live < 0) ? text.size() : live;
   endfunction

   // one byte transfer; valid stays high across back-to-back bytes
   task automatic send_byte(input logic [7:0] b, input logic fin, input bit steady);
      int gap;
      gap = steady ? 0 : idle_span();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.byte_in <= b;
      req_chan.last_byte <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_list(input logic [8:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8], 1'b0);
   endtask

   // wait until every predicted unit has come back, then let the pipe drain
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_fold(input logic value);
      csr_chan.valid <= 1'b1;
      csr_chan.fold_case <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // receiver: short runs with random stalls, now and then a long stretch of steady ready
   initial begin
      int run;
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         gap = idle_span();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [8:0] seq[$];
      int live_sent;
      bit steady;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.byte_in <= 8'h00;
      req_chan.last_byte <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.fold_case <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed strings with fold_case at its reset value
      seq = '{
         {Last, 8'h00},                                           // zero byte alone
         {More, 8'hC0}, {Last, 8'h80},                            // overlong two-byte zero
         {More, 8'hEF}, {More, 8'hBF}, {Last, 8'hBF},             // top of the bmp
         {More, 8'hF0}, {More, 8'h90}, {More, 8'h80}, {Last, 8'h80},  // first pair
         {More, 8'hF7}, {More, 8'hBF}, {More, 8'hBF}, {Last, 8'hBF},  // beyond 10ffff, masked
         {Last, 8'h80},                                           // bad lead as final byte
         {More, 8'hFF}, {More, 8'h41}, {Last, 8'h42},             // bad lead, rest dropped
         {More, 8'hE2}, {Last, 8'h41},                            // bad continuation
         {Last, 8'hC3},                                           // cut off after the lead
         {More, 8'hE2}, {Last, 8'h82}                             // cut off mid-sequence
      };
      send_list(seq);

      // letters and their neighbors with folding on
      settle();
      write_fold(1'b1);
      seq = '{{More, 8'h40}, {More, 8'h41}, {More, 8'h5A}, {More, 8'h5B}, {Last, 8'h7F}};
      send_list(seq);

      // random strings, fold_case alternating between phases
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         write_fold(logic'(phase % 2));
         live_sent = 0;
         while (live_sent < 100) begin
            live_sent += make_string();
            steady = ($urandom_range(0, 4) == 0);
            foreach (text[i]) send_byte(text[i], logic'(i == text.size() - 1), steady);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
